// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

  localparam int unsigned TimersDef = 16;

  localparam int unsigned OpW       = 2;
  localparam int unsigned NowW      = 40;
  localparam int unsigned PeriodW   = 31;
  localparam int unsigned IdW       = 32;
  localparam int unsigned DeadlineW = 41;
  localparam int unsigned StatusW   = 2;

  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 112;

  typedef enum logic [OpW-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_POLL   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // One stored timer.
  typedef struct packed {
    logic [IdW-1:0]       ident;
    logic [PeriodW-1:0]   period;
    logic [DeadlineW-1:0] deadline;
  } entry_t;

  // Commands from the sequencer to the slot table.
  typedef struct packed {
    logic scan_start;
    logic wr_en;
    logic clr_en;
  } tbl_ctrl_t;

  // Status from the slot table back to the sequencer.
  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic hit_found;
    logic free_found;
  } tbl_stat_t;

endpackage

// ===== rtl/pts_slot_table.sv =====
`timescale 1ns / 1ps

module pts_slot_table #(
  parameter int unsigned TIMERS = pts_pkg::TimersDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pts_pkg::tbl_ctrl_t          ctrl_i,
  input  logic [$clog2(TIMERS)-1:0]   wr_slot_i,
  input  pts_pkg::entry_t             wr_entry_i,
  input  logic [$clog2(TIMERS)-1:0]   clr_slot_i,
  input  logic [pts_pkg::IdW-1:0]     match_id_i,
  output pts_pkg::tbl_stat_t          stat_o,
  output logic [$clog2(TIMERS)-1:0]   best_slot_o,
  output pts_pkg::entry_t             best_entry_o,
  output logic [$clog2(TIMERS)-1:0]   hit_slot_o,
  output logic [$clog2(TIMERS)-1:0]   free_slot_o
);
  import pts_pkg::*;

  localparam int unsigned SlotW = $clog2(TIMERS);
  localparam int unsigned CntW  = SlotW + 1;
  localparam logic [CntW-1:0] CntEnd = CntW'(TIMERS);

  entry_t            mem [TIMERS];
  logic [TIMERS-1:0] valid_q;

  logic [CntW-1:0]  cnt_q;
  logic             scanning_q;
  logic             chk_vld_q;
  logic [SlotW-1:0] chk_slot_q;
  entry_t           rd_data_q;

  logic             best_found_q;
  logic [SlotW-1:0] best_slot_q;
  entry_t           best_q;
  logic             hit_found_q;
  logic [SlotW-1:0] hit_slot_q;

  logic             issue;
  logic [SlotW-1:0] rd_addr;
  logic             scan_done;
  logic             chk_live;
  logic             better;
  logic             free_found;
  logic [SlotW-1:0] free_slot;

  assign issue     = scanning_q && (cnt_q < CntEnd);
  assign rd_addr   = cnt_q[SlotW-1:0];
  assign scan_done = scanning_q && (cnt_q == CntEnd) && !chk_vld_q;
  assign chk_live  = chk_vld_q && valid_q[chk_slot_q];

  // Strict compare keeps the lower slot when deadline and id both tie.
  assign better = !best_found_q ||
                  (rd_data_q.deadline < best_q.deadline) ||
                  ((rd_data_q.deadline == best_q.deadline) &&
                   (rd_data_q.ident < best_q.ident));

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_slot_i] <= wr_entry_i;
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      cnt_q        <= '0;
      scanning_q   <= 1'b0;
      chk_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      hit_found_q  <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[wr_slot_i] <= 1'b1;
      end
      if (ctrl_i.clr_en) begin
        valid_q[clr_slot_i] <= 1'b0;
      end
      chk_vld_q <= issue;
      if (ctrl_i.scan_start) begin
        cnt_q        <= '0;
        scanning_q   <= 1'b1;
        best_found_q <= 1'b0;
        hit_found_q  <= 1'b0;
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + CntW'(1);
        end
        if (scan_done) begin
          scanning_q <= 1'b0;
        end
        if (chk_live && better) begin
          best_found_q <= 1'b1;
        end
        if (chk_live && !hit_found_q && (rd_data_q.ident == match_id_i)) begin
          hit_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      chk_slot_q <= rd_addr;
    end
    if (!ctrl_i.scan_start && chk_live && better) begin
      best_slot_q <= chk_slot_q;
      best_q      <= rd_data_q;
    end
    if (!ctrl_i.scan_start && chk_live && !hit_found_q &&
        (rd_data_q.ident == match_id_i)) begin
      hit_slot_q <= chk_slot_q;
    end
  end

  assign stat_o.scan_done  = scan_done;
  assign stat_o.best_found = best_found_q;
  assign stat_o.hit_found  = hit_found_q;
  assign stat_o.free_found = free_found;
  assign best_slot_o       = best_slot_q;
  assign best_entry_o      = best_q;
  assign hit_slot_o        = hit_slot_q;
  assign free_slot_o       = free_slot;

  a_wr_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.wr_en && ctrl_i.clr_en))
    else $error("slot write and slot clear in the same cycle");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.scan_start |-> (!scanning_q || scan_done))
    else $error("scan started while another scan is running");

  a_chk_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> scanning_q)
    else $error("read data checked outside of a scan");

endmodule

// ===== rtl/periodic_timer_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Scans: create, an unknown operation, a delete that misses and a poll that does
//   not fire each run one full scan of the slot memory from request to result; a
//   delete that hits and a poll that fires run two full scans.
// Throughput: one request at a time, the next accepted once the result is staged.
// Reset: rst_ni clears all slot valid bits, the id counter and the handshakes.

module periodic_timer_scheduler_unit #(
  parameter int unsigned TIMERS = pts_pkg::TimersDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0 up: now_ms (40), period_ms (31), timer_id (32), zero fill.
  input  logic [pts_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0 up: operation (2).
  input  logic [pts_pkg::OpW-1:0]      s_axis_tuser_i,
  // Result channel.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // Fields from bit 0 up: status (2), fired (1), fired_id (32), new_id (32),
  // time_to_next_ms (41), zero fill.
  output logic [pts_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import pts_pkg::*;

  localparam int unsigned SlotW = $clog2(TIMERS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
  localparam logic [2:0] S_EXEC  = 3'd1;  // create write, first scan launched
  localparam logic [2:0] S_PICK  = 3'd2;  // first scan: delete lookup or poll pick
  localparam logic [2:0] S_FINAL = 3'd3;  // final scan, after any table change
  localparam logic [2:0] S_OUT   = 3'd4;  // result waits for the output register

  logic [2:0]           state_q, state_d;
  logic [IdW-1:0]       id_cnt_q, id_cnt_d;
  logic                 m_tvalid_q, m_tvalid_d;
  logic [OutDataW-1:0]  m_tdata_q, m_tdata_d;

  op_e                  op_q, op_d;
  logic [NowW-1:0]      now_q, now_d;
  logic [PeriodW-1:0]   period_q, period_d;
  logic [IdW-1:0]       tid_q, tid_d;

  status_e              res_status_q, res_status_d;
  logic                 res_fired_q, res_fired_d;
  logic [IdW-1:0]       res_fired_id_q, res_fired_id_d;
  logic [IdW-1:0]       res_new_id_q, res_new_id_d;
  logic [DeadlineW-1:0] res_ttn_q, res_ttn_d;

  tbl_ctrl_t            tbl_ctrl;
  tbl_stat_t            tbl_stat;
  logic [SlotW-1:0]     wr_slot;
  entry_t               wr_entry;
  logic [SlotW-1:0]     best_slot;
  entry_t               best_entry;
  logic [SlotW-1:0]     hit_slot;
  logic [SlotW-1:0]     free_slot;

  logic                 in_accept;
  logic [DeadlineW-1:0] now_ext;
  logic [DeadlineW-1:0] ttn;
  logic                 due;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign now_ext   = {1'b0, now_q};

  // Time to the earliest deadline of the table as the last scan saw it.
  assign ttn = (tbl_stat.best_found && (best_entry.deadline > now_ext)) ?
               (best_entry.deadline - now_ext) : '0;
  assign due = now_ext >= best_entry.deadline;

  always_comb begin
    state_d        = state_q;
    id_cnt_d       = id_cnt_q;
    m_tvalid_d     = m_tvalid_q;
    m_tdata_d      = m_tdata_q;
    op_d           = op_q;
    now_d          = now_q;
    period_d       = period_q;
    tid_d          = tid_q;
    res_status_d   = res_status_q;
    res_fired_d    = res_fired_q;
    res_fired_id_d = res_fired_id_q;
    res_new_id_d   = res_new_id_q;
    res_ttn_d      = res_ttn_q;
    tbl_ctrl       = '0;
    wr_slot        = free_slot;
    wr_entry.ident    = id_cnt_q + IdW'(1);
    wr_entry.period   = period_q;
    wr_entry.deadline = now_ext + DeadlineW'(period_q);

    if (m_tvalid_q && m_axis_tready_i) begin
      m_tvalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d           = op_e'(s_axis_tuser_i);
          now_d          = s_axis_tdata_i[NowW-1:0];
          period_d       = s_axis_tdata_i[NowW+PeriodW-1:NowW];
          tid_d          = s_axis_tdata_i[NowW+PeriodW+IdW-1:NowW+PeriodW];
          res_status_d   = ST_OK;
          res_fired_d    = 1'b0;
          res_fired_id_d = '0;
          res_new_id_d   = '0;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        tbl_ctrl.scan_start = 1'b1;
        unique case (op_q)
          OP_CREATE: begin
            if (tbl_stat.free_found) begin
              tbl_ctrl.wr_en = 1'b1;
              id_cnt_d       = wr_entry.ident;
              res_new_id_d   = wr_entry.ident;
            end else begin
              res_status_d = ST_FULL;
            end
            state_d = S_FINAL;
          end
          OP_DELETE, OP_POLL: state_d = S_PICK;
          default:            state_d = S_FINAL;
        endcase
      end
      S_PICK: begin
        if (tbl_stat.scan_done) begin
          res_ttn_d = ttn;
          state_d   = S_OUT;
          if (op_q == OP_DELETE) begin
            if (tbl_stat.hit_found) begin
              // The table changes, so the earliest timer is found again.
              tbl_ctrl.clr_en     = 1'b1;
              tbl_ctrl.scan_start = 1'b1;
              state_d             = S_FINAL;
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end else if (!tbl_stat.best_found) begin
            res_status_d = ST_EMPTY;
          end else if (due) begin
            // The earliest timer fires and moves to its next deadline.
            wr_slot             = best_slot;
            wr_entry.ident      = best_entry.ident;
            wr_entry.period     = best_entry.period;
            wr_entry.deadline   = now_ext + DeadlineW'(best_entry.period);
            tbl_ctrl.wr_en      = 1'b1;
            tbl_ctrl.scan_start = 1'b1;
            res_fired_d         = 1'b1;
            res_fired_id_d      = best_entry.ident;
            state_d             = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (tbl_stat.scan_done) begin
          res_ttn_d = ttn;
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_tvalid_q || m_axis_tready_i) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {4'b0, res_ttn_q, res_new_id_q, res_fired_id_q,
                        res_fired_q, res_status_q};
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      id_cnt_q   <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      id_cnt_q   <= id_cnt_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_tdata_q      <= m_tdata_d;
    op_q           <= op_d;
    now_q          <= now_d;
    period_q       <= period_d;
    tid_q          <= tid_d;
    res_status_q   <= res_status_d;
    res_fired_q    <= res_fired_d;
    res_fired_id_q <= res_fired_id_d;
    res_new_id_q   <= res_new_id_d;
    res_ttn_q      <= res_ttn_d;
  end

  pts_slot_table #(
    .TIMERS (TIMERS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tbl_ctrl),
    .wr_slot_i    (wr_slot),
    .wr_entry_i   (wr_entry),
    .clr_slot_i   (hit_slot),
    .match_id_i   (tid_q),
    .stat_o       (tbl_stat),
    .best_slot_o  (best_slot),
    .best_entry_o (best_entry),
    .hit_slot_o   (hit_slot),
    .free_slot_o  (free_slot)
  );

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_stat.scan_done |-> (state_q == S_PICK || state_q == S_FINAL))
    else $error("scan finished while the sequencer was not waiting for it");

  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (id_cnt_q != $past(id_cnt_q)) |-> (id_cnt_q == $past(id_cnt_q) + IdW'(1)))
    else $error("id counter moved by other than one");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tdata_q[StatusW]) |-> (m_tdata_q[StatusW-1:0] == ST_OK))
    else $error("fired result without status ok");

  a_full_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && (m_tdata_q[StatusW-1:0] == ST_FULL)) |->
      (m_tdata_q[StatusW+1+2*IdW-1:StatusW+1+IdW] == '0))
    else $error("full table result carries a new id");

endmodule
